// ===== sv/srk_pkg.sv =====
// Shared constants, types and helpers of the symmetric rank-k update block.
// Used by srk_mul and symmetric_rank_k_update_top; depends on nothing else.
`default_nettype none
package srk_pkg;

	localparam int MAX_N  = 8;
	localparam int MAX_K  = 8;
	localparam int IDX_W  = 3;               // row and column index width
	localparam int ADDR_W = 2 * IDX_W;       // store address {row, col}
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int CNT_W  = 4;               // holds 0..MAX_N and 0..MAX_K
	localparam int A_W    = 16;              // Q8.8
	localparam int C_W    = 32;              // Q16.16
	localparam int DOT_W  = 36;              // sum of MAX_K Q16.16 products
	localparam int PROD_W = DOT_W + A_W;     // shared multiplier result
	localparam int RND_SH = 8;               // Q24.24 to Q16.16

	localparam logic [1:0] OP_LOAD_A  = 2'd0;
	localparam logic [1:0] OP_LOAD_C  = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;

	localparam logic [2:0] REG_UPPER = 3'd0;
	localparam logic [2:0] REG_TRANS = 3'd1;
	localparam logic [2:0] REG_ORDER = 3'd2;
	localparam logic [2:0] REG_INNER = 3'd3;
	localparam logic [2:0] REG_ALPHA = 3'd4;
	localparam logic [2:0] REG_BETA  = 3'd5;

	typedef logic [1:0] mul_sel_t;
	localparam mul_sel_t SEL_AA    = 2'd0;
	localparam mul_sel_t SEL_ALPHA = 2'd1;
	localparam mul_sel_t SEL_BETA  = 2'd2;

	// Shift a pre-rounded Q24.24 sum down to Q16.16 and saturate to 32 bits.
	function automatic logic [C_W-1:0] round_sat(input logic [PROD_W-1:0] t);
		logic [PROD_W-1:0] q;
		logic [C_W-1:0]    r;
		q = PROD_W'($signed(t) >>> RND_SH);
		if (!q[PROD_W-1] && (|q[PROD_W-2:C_W-1])) begin
			r = {1'b0, {(C_W-1){1'b1}}};
		end else if (q[PROD_W-1] && !(&q[PROD_W-2:C_W-1])) begin
			r = {1'b1, {(C_W-1){1'b0}}};
		end else begin
			r = q[C_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/symmetric_rank_k_update_top.sv =====
// Top level of the fixed-point symmetric rank-k update engine (SYRK).
// Depends on srk_pkg and instantiates the shared multiplier srk_mul.
`default_nettype none
// The block holds matrix A (8 by 8 store of Q8.8 values) and the symmetric
// matrix C (8 by 8 store of Q16.16 values). An input word with tuser 0 loads
// one A element (low 16 bits of the value), tuser 1 loads one C element, and
// tuser 2 starts a compute: on the chosen triangle only, C becomes
// alpha*A*A^T + beta*C (transpose_mode 0) or alpha*A^T*A + beta*C
// (transpose_mode 1), each element rounded half up once and saturated. The
// new triangle is written back and sent out column by column as
// n*(n+1)/2 words, with tlast on the final one; an order of zero sends none.
// Code 3 is accepted and dropped. A compute runs one output element at a
// time through a single shared multiplier: multiply-accumulate of the k A
// products, a drain of the read and multiplier pipeline until it is seen
// empty, then alpha scaling, beta scaling and a round-and-write step, plus
// any wait of the output on m_axis_tready. The input is not ready during a
// compute; it is ready again as soon as the last element sits in the output
// register. C is cleared at reset through per-entry valid bits, so no
// clearing pass is needed. An A entry must be loaded before a compute reads
// it. The user must write registers over APB only while the block is idle;
// the block itself does not enforce this. order_n and inner_k above 8 act
// as 8.
module symmetric_rank_k_update_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration port, register i at byte address 4*i.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// Input stream.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // row_index[2:0], col_index[5:3],
	                                         // element_value[37:6], zero[39:38]
	input  wire logic [1:0]  s_axis_tuser,  // operation[1:0]
	// Output stream.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [39:0] m_axis_tdata,  // out_row[2:0], out_col[5:3],
	                                         // out_value[37:6], zero[39:38]
	output logic             m_axis_tlast   // last_element
);
	import srk_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DOT   = 3'd1;
	localparam logic [2:0] ST_ALPHA = 3'd2;
	localparam logic [2:0] ST_BETA  = 3'd3;
	localparam logic [2:0] ST_SUM   = 3'd4;

	// Configuration registers.
	logic             upper_q;
	logic             trans_q;
	logic [CNT_W-1:0] order_q;
	logic [CNT_W-1:0] inner_q;
	logic [A_W-1:0]   alpha_q;
	logic [A_W-1:0]   beta_q;

	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= 1'b1;
			trans_q <= 1'b0;
			order_q <= CNT_W'(MAX_N);
			inner_q <= CNT_W'(MAX_K);
			alpha_q <= A_W'(256);
			beta_q  <= A_W'(256);
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_UPPER: upper_q <= pwdata[0];
				REG_TRANS: trans_q <= pwdata[0];
				REG_ORDER: order_q <= pwdata[CNT_W-1:0];
				REG_INNER: inner_q <= pwdata[CNT_W-1:0];
				REG_ALPHA: alpha_q <= pwdata[A_W-1:0];
				REG_BETA:  beta_q  <= pwdata[A_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_UPPER: prdata = {31'd0, upper_q};
			REG_TRANS: prdata = {31'd0, trans_q};
			REG_ORDER: prdata = {{(32-CNT_W){1'b0}}, order_q};
			REG_INNER: prdata = {{(32-CNT_W){1'b0}}, inner_q};
			REG_ALPHA: prdata = {{(32-A_W){alpha_q[A_W-1]}}, alpha_q};
			REG_BETA:  prdata = {{(32-A_W){beta_q[A_W-1]}}, beta_q};
			default:   prdata = '0;
		endcase
	end

	// Effective order and depth, clamped to the store size.
	logic [CNT_W-1:0] n_eff;
	logic [CNT_W-1:0] k_eff;
	logic [CNT_W-1:0] n_m1;
	assign n_eff = (order_q > CNT_W'(MAX_N)) ? CNT_W'(MAX_N) : order_q;
	assign k_eff = (inner_q > CNT_W'(MAX_K)) ? CNT_W'(MAX_K) : inner_q;
	assign n_m1  = n_eff - CNT_W'(1);

	// Input word fields.
	logic [IDX_W-1:0] in_row;
	logic [IDX_W-1:0] in_col;
	logic [C_W-1:0]   in_val;
	logic [1:0]       in_op;
	logic             in_acc;
	assign in_row = s_axis_tdata[IDX_W-1:0];
	assign in_col = s_axis_tdata[2*IDX_W-1:IDX_W];
	assign in_val = s_axis_tdata[2*IDX_W+C_W-1:2*IDX_W];
	assign in_op  = s_axis_tuser;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// Sequencer state.
	logic [2:0]        state_q;
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  j_q;
	logic [CNT_W-1:0]  l_q;
	logic              rd_v_s1;
	logic              mul_v_s2;
	logic [DOT_W-1:0]  dot_q;
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] prod_q;

	// Output register.
	logic             m_valid_q;
	logic [IDX_W-1:0] o_row_q;
	logic [IDX_W-1:0] o_col_q;
	logic [C_W-1:0]   o_val_q;
	logic             o_last_q;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = {2'b00, o_val_q, o_col_q, o_row_q};

	// Triangle walk: upper runs i from 0 to j, lower runs i from j to n-1.
	logic col_end;
	logic last_elem;
	logic out_load;
	assign col_end   = upper_q ? (i_q == j_q) : ({1'b0, i_q} == n_m1);
	assign last_elem = col_end && ({1'b0, j_q} == n_m1);
	assign out_load  = (state_q == ST_SUM) && (!m_valid_q || m_axis_tready);

	// A store: one write port, two registered read ports.
	logic [A_W-1:0]    a_mem [DEPTH];
	logic [A_W-1:0]    a_row_s1;
	logic [A_W-1:0]    a_col_s1;
	logic [IDX_W-1:0]  l_idx;
	logic [ADDR_W-1:0] a_addr_i;
	logic [ADDR_W-1:0] a_addr_j;
	logic              issue;
	assign l_idx    = l_q[IDX_W-1:0];
	assign a_addr_i = trans_q ? {l_idx, i_q} : {i_q, l_idx};
	assign a_addr_j = trans_q ? {l_idx, j_q} : {j_q, l_idx};
	assign issue    = (state_q == ST_DOT) && (l_q < k_eff);

	always_ff @(posedge clk) begin
		if (in_acc && in_op == OP_LOAD_A) begin
			a_mem[{in_row, in_col}] <= in_val[A_W-1:0];
		end
		a_row_s1 <= a_mem[a_addr_i];
		a_col_s1 <= a_mem[a_addr_j];
	end

	// C store: one write port, one registered read port at (i, j).
	// Entries never written read as zero through the valid bits.
	logic [C_W-1:0]    c_mem [DEPTH];
	logic [DEPTH-1:0]  c_vld_q;
	logic [C_W-1:0]    c_rd_q;
	logic              c_rdv_q;
	logic [C_W-1:0]    c_old;
	logic [C_W-1:0]    new_val;
	logic              c_we;
	logic [ADDR_W-1:0] c_waddr;
	logic [C_W-1:0]    c_wdata;
	logic [PROD_W-1:0] sum;

	assign sum     = acc_q + prod_q;
	assign new_val = round_sat(sum);
	assign c_we    = (in_acc && in_op == OP_LOAD_C) || out_load;
	assign c_waddr = out_load ? {i_q, j_q} : {in_row, in_col};
	assign c_wdata = out_load ? new_val : in_val;
	assign c_old   = c_rdv_q ? c_rd_q : '0;

	always_ff @(posedge clk) begin
		if (c_we) begin
			c_mem[c_waddr] <= c_wdata;
		end
		c_rd_q <= c_mem[{i_q, j_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_vld_q <= '0;
			c_rdv_q <= 1'b0;
		end else begin
			if (c_we) begin
				c_vld_q[c_waddr] <= 1'b1;
			end
			c_rdv_q <= c_vld_q[{i_q, j_q}];
		end
	end

	// The one multiplier: A products, then dot*alpha, then beta*C. The beta
	// product is kept selected through write-back so that it stays in place
	// while the output register is full.
	mul_sel_t mul_sel;
	always_comb begin
		case (state_q)
			ST_ALPHA:        mul_sel = SEL_ALPHA;
			ST_BETA, ST_SUM: mul_sel = SEL_BETA;
			default:         mul_sel = SEL_AA;
		endcase
	end

	srk_mul u_mul (
		.clk    (clk),
		.sel    (mul_sel),
		.a_row  (a_row_s1),
		.a_col  (a_col_s1),
		.dot    (dot_q),
		.c_old  (c_old),
		.alpha  (alpha_q),
		.beta   (beta_q),
		.prod_q (prod_q)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			l_q      <= '0;
			rd_v_s1  <= 1'b0;
			mul_v_s2 <= 1'b0;
		end else begin
			rd_v_s1  <= issue;
			mul_v_s2 <= (state_q == ST_DOT) && rd_v_s1;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_op == OP_COMPUTE && n_eff != '0) begin
						state_q <= ST_DOT;
						i_q     <= '0;
						j_q     <= '0;
						l_q     <= '0;
					end
				end
				ST_DOT: begin
					if (issue) begin
						l_q <= l_q + CNT_W'(1);
					end else if (!rd_v_s1 && !mul_v_s2) begin
						state_q <= ST_ALPHA;
					end
				end
				ST_ALPHA: state_q <= ST_BETA;
				ST_BETA:  state_q <= ST_SUM;
				ST_SUM: begin
					if (out_load) begin
						l_q <= '0;
						if (last_elem) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DOT;
							if (col_end) begin
								j_q <= j_q + IDX_W'(1);
								i_q <= upper_q ? '0 : j_q + IDX_W'(1);
							end else begin
								i_q <= i_q + IDX_W'(1);
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath accumulators. The rounding constant is folded in with the
	// alpha product so the final cycle only adds and saturates.
	always_ff @(posedge clk) begin
		if (state_q != ST_DOT) begin
			dot_q <= '0;
		end else if (mul_v_s2) begin
			dot_q <= dot_q + prod_q[DOT_W-1:0];
		end
		if (state_q == ST_BETA) begin
			acc_q <= prod_q + PROD_W'(1 << (RND_SH - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_row_q  <= i_q;
			o_col_q  <= j_q;
			o_val_q  <= new_val;
			o_last_q <= last_elem;
		end
	end

	// The walk never leaves the chosen triangle of the active order.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |->
			(({1'b0, j_q} < n_eff) && (upper_q ? (i_q <= j_q) : (i_q >= j_q))))
		else $error("element walk left the triangle");

	// The depth counter stops at k.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DOT) |-> (l_q <= k_eff))
		else $error("depth counter ran past k");

	// The product pipeline is empty once alpha scaling starts.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ALPHA) |-> (!rd_v_s1 && !mul_v_s2))
		else $error("alpha scaling started with products in flight");

	// A result word enters the output register only in the write-back cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(state_q) == ST_SUM))
		else $error("output word appeared outside write-back");

endmodule
`default_nettype wire

// ===== sv/srk_mul.sv =====
// Shared signed multiplier with its operand select and output register.
// Depends on srk_pkg for widths and select codes.
`default_nettype none
module srk_mul (
	input  wire logic                      clk,
	input  wire srk_pkg::mul_sel_t         sel,
	input  wire logic [srk_pkg::A_W-1:0]   a_row,
	input  wire logic [srk_pkg::A_W-1:0]   a_col,
	input  wire logic [srk_pkg::DOT_W-1:0] dot,
	input  wire logic [srk_pkg::C_W-1:0]   c_old,
	input  wire logic [srk_pkg::A_W-1:0]   alpha,
	input  wire logic [srk_pkg::A_W-1:0]   beta,
	output logic      [srk_pkg::PROD_W-1:0] prod_q
);
	import srk_pkg::*;

	logic signed [DOT_W-1:0] op_a;
	logic signed [A_W-1:0]   op_b;

	always_comb begin
		case (sel)
			SEL_AA: begin
				op_a = {{(DOT_W-A_W){a_row[A_W-1]}}, a_row};
				op_b = a_col;
			end
			SEL_ALPHA: begin
				op_a = dot;
				op_b = alpha;
			end
			SEL_BETA: begin
				op_a = {{(DOT_W-C_W){c_old[C_W-1]}}, c_old};
				op_b = beta;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a * op_b);
	end

endmodule
`default_nettype wire

// ===== tb/tb_symmetric_rank_k_update_top.sv =====
// Self-checking testbench for the symmetric rank-k update engine (SYRK).
// Depends on srk_pkg and symmetric_rank_k_update_top; checks every output word
// against an in-bench predictor of the A and C stores under random idling.
module tb_symmetric_rank_k_update_top;
	import srk_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT      = 1_000_000;
	localparam int SETTLE_CYCLES    = 24;
	localparam int WORDS_PER_PHASE  = 60;
	localparam int RANDOM_PHASES    = 8;
	localparam int REPORT_LIMIT     = 10;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// One input word; hold makes the sender wait until every expected element has come.
	typedef struct packed {
		logic        hold;
		logic [1:0]  op;
		logic [2:0]  row;
		logic [2:0]  col;
		logic [31:0] value;
	} syrk_word_t;

	typedef struct packed {
		logic [2:0]  row;
		logic [2:0]  col;
		logic [31:0] value;
		logic        last;
	} syrk_elem_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	// Predictor copy of the registers, reset values included.
	logic               cfg_upper = 1'b1;
	logic               cfg_trans = 1'b0;
	logic [3:0]         cfg_order = 4'd8;
	logic [3:0]         cfg_inner = 4'd8;
	logic signed [15:0] cfg_alpha = 16'sh0100;
	logic signed [15:0] cfg_beta  = 16'sh0100;

	logic signed [A_W-1:0] a_mem [8][8];
	logic signed [C_W-1:0] c_mem [8][8];
	bit                    a_loaded [8][8];

	syrk_word_t  word_queue[$];
	syrk_elem_t  expected_elems[$];
	int unsigned send_gap_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatches = 0;
	logic        presenting;
	syrk_elem_t  seen, wanted;

	symmetric_rank_k_update_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int clamp_dim(input logic [3:0] v, input int lim);
		return (int'(v) > lim) ? lim : int'(v);
	endfunction

	// Q24.24 to Q16.16: add half an LSB, floor by the arithmetic shift, then saturate.
	function automatic logic signed [31:0] to_q16(input longint acc);
		longint q;
		q = (acc + 128) >>> RND_SH;
		if (q > 64'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end
		if (q < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return q[31:0];
	endfunction

	// Applies one accepted word to the store copies and queues the elements it emits.
	function automatic void syrk_apply(input syrk_word_t w);
		int         n, k, total, count, lo, hi;
		longint     dot, acc;
		syrk_elem_t e;
		case (w.op)
			OP_LOAD_A: begin
				a_mem[w.row][w.col] = w.value[A_W-1:0];
			end
			OP_LOAD_C: begin
				c_mem[w.row][w.col] = w.value;
			end
			OP_COMPUTE: begin
				n = clamp_dim(cfg_order, MAX_N);
				k = clamp_dim(cfg_inner, MAX_K);
				total = n * (n + 1) / 2;
				count = 0;
				// Column by column, rows limited to the chosen triangle.
				for (int j = 0; j < n; j++) begin
					lo = cfg_upper ? 0 : j;
					hi = cfg_upper ? j : n - 1;
					for (int i = lo; i <= hi; i++) begin
						dot = 0;
						for (int l = 0; l < k; l++) begin
							if (cfg_trans) begin
								dot += longint'(a_mem[l][i]) * longint'(a_mem[l][j]);
							end else begin
								dot += longint'(a_mem[i][l]) * longint'(a_mem[j][l]);
							end
						end
						acc = dot * longint'(cfg_alpha);
						if (cfg_beta != 0) begin
							acc += longint'(cfg_beta) * longint'(c_mem[i][j]);
						end
						c_mem[i][j] = to_q16(acc);
						e.row = 3'(i);
						e.col = 3'(j);
						e.value = c_mem[i][j];
						e.last = (count + 1 == total);
						expected_elems.push_back(e);
						count++;
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic [31:0] rand_elem();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 3))
			0: begin
			end
			1: begin
				r = $urandom_range(0, 2047) - 1024;
			end
			2: begin
				case ($urandom_range(0, 3))
					0: r = 32'h7FFF_FFFF;
					1: r = 32'h8000_0000;
					2: r = 32'h0000_7FFF;
					default: r = 32'hFFFF_8000;
				endcase
			end
			default: begin
				// A value near +-2.0 in Q8.8 with junk in the upper half.
				r[15:0] = 16'($urandom_range(0, 1023)) - 16'd512;
			end
		endcase
		return r;
	endfunction

	function automatic logic [3:0] rand_dim();
		if ($urandom_range(0, 9) == 0) begin
			return 4'($urandom_range(0, 15));
		end
		return 4'($urandom_range(1, 4));
	endfunction

	function automatic logic [15:0] rand_scale();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1, 2: return 16'($urandom);
			default: return 16'($urandom_range(0, 767)) - 16'd384;
		endcase
	endfunction

	function automatic void push_word(input logic [1:0] op, input logic [2:0] row,
			input logic [2:0] col, input logic [31:0] value, input logic hold);
		syrk_word_t w;
		w.hold = hold;
		w.op = op;
		w.row = row;
		w.col = col;
		w.value = value;
		if (op == OP_LOAD_A) begin
			a_loaded[row][col] = 1'b1;
		end
		word_queue.push_back(w);
	endfunction

	// Loads any A entry the compute will read that has never been written, then
	// queues the compute itself.
	function automatic void push_compute(input logic hold);
		int n, k;
		n = clamp_dim(cfg_order, MAX_N);
		k = clamp_dim(cfg_inner, MAX_K);
		for (int i = 0; i < n; i++) begin
			for (int l = 0; l < k; l++) begin
				if (cfg_trans && !a_loaded[l][i]) begin
					push_word(OP_LOAD_A, 3'(l), 3'(i), rand_elem(), 1'b0);
				end else if (!cfg_trans && !a_loaded[i][l]) begin
					push_word(OP_LOAD_A, 3'(i), 3'(l), rand_elem(), 1'b0);
				end
			end
		end
		push_word(OP_COMPUTE, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom,
			hold);
	endfunction

	function automatic void note_mismatch(input string what, input syrk_elem_t want,
			input syrk_elem_t got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("mismatch %0d, %s: expected (%0d,%0d) %h last %b, got (%0d,%0d) %h last %b",
				mismatches, what, want.row, want.col, want.value, want.last,
				got.row, got.col, got.value, got.last);
		end
	endfunction

	// APB write: setup cycle, then access cycle; the register takes the value at
	// the edge that sees psel, penable, pwrite and pready all high.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_UPPER: cfg_upper = val[0];
			REG_TRANS: cfg_trans = val[0];
			REG_ORDER: cfg_order = val[3:0];
			REG_INNER: cfg_inner = val[3:0];
			REG_ALPHA: cfg_alpha = val[15:0];
			REG_BETA:  cfg_beta = val[15:0];
			default: begin
			end
		endcase
	endtask

	task automatic set_config(input logic upper, input logic trans, input logic [3:0] order,
			input logic [3:0] inner, input logic [15:0] alpha, input logic [15:0] beta);
		write_reg(REG_UPPER, {31'd0, upper});
		write_reg(REG_TRANS, {31'd0, trans});
		write_reg(REG_ORDER, {28'd0, order});
		write_reg(REG_INNER, {28'd0, inner});
		write_reg(REG_ALPHA, {16'd0, alpha});
		write_reg(REG_BETA, {16'd0, beta});
	endtask

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_SENDER: begin
				send_gap_pct = 78;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_gap_pct = 0;
				recv_stall_pct = 78;
			end
			IDLE_BOTH: begin
				send_gap_pct = 14;
				recv_stall_pct = 14;
			end
			default: begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	// Waits until every queued word is accepted and every expected element has
	// come, then gives trailing loads time to finish before the block is touched.
	task automatic drain();
		while (word_queue.size() != 0 || expected_elems.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Driver: a word leaves the queue only when it is accepted, so the queue
	// stays non-empty while a word is on the bus.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				syrk_apply(word_queue.pop_front());
				presenting = 1'b0;
			end else begin
				presenting = s_axis_tvalid;
			end
			if (!presenting && word_queue.size() != 0 &&
					$urandom_range(0, 99) >= send_gap_pct &&
					!(word_queue[0].hold && expected_elems.size() != 0)) begin
				s_axis_tdata <= {2'b00, word_queue[0].value, word_queue[0].col,
					word_queue[0].row};
				s_axis_tuser <= word_queue[0].op;
				presenting = 1'b1;
			end
			s_axis_tvalid <= presenting;
		end
	end

	// Monitor: checks each accepted output word against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.row = m_axis_tdata[2:0];
				seen.col = m_axis_tdata[5:3];
				seen.value = m_axis_tdata[37:6];
				seen.last = m_axis_tlast;
				if (expected_elems.size() == 0) begin
					note_mismatch("element with none expected", seen, seen);
				end else begin
					wanted = expected_elems.pop_front();
					if (seen !== wanted) begin
						note_mismatch("element differs", wanted, seen);
					end
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		int unsigned pick;
		for (int r = 0; r < 8; r++) begin
			for (int c = 0; c < 8; c++) begin
				c_mem[r][c] = '0;
				a_mem[r][c] = '0;
			end
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extreme A and C values, upper bits of an A word that must be
		// ignored, the unused code, and a second compute that waits for the first
		// triangle to drain and then builds on the stored C.
		set_idle(IDLE_NONE);
		set_config(1'b1, 1'b0, 4'd3, 4'd2, 16'h0100, 16'h0100);
		push_word(OP_LOAD_A, 3'd0, 3'd0, 32'hFFFF_7FFF, 1'b0);
		push_word(OP_LOAD_A, 3'd0, 3'd1, 32'h0000_8000, 1'b0);
		push_word(OP_LOAD_A, 3'd1, 3'd0, 32'h0000_0100, 1'b0);
		push_word(OP_LOAD_A, 3'd1, 3'd1, 32'hFFFF_FFFF, 1'b0);
		push_word(OP_LOAD_A, 3'd2, 3'd0, 32'h0000_0000, 1'b0);
		push_word(OP_LOAD_A, 3'd2, 3'd1, 32'h1234_0080, 1'b0);
		push_word(OP_LOAD_C, 3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0);
		push_word(OP_LOAD_C, 3'd0, 3'd1, 32'h8000_0000, 1'b0);
		push_word(OP_LOAD_C, 3'd1, 3'd2, 32'h0001_0000, 1'b0);
		push_word(OP_LOAD_C, 3'd2, 3'd2, 32'hFFFF_0000, 1'b0);
		push_word(OP_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0);
		push_compute(1'b0);
		push_compute(1'b1);
		drain();

		// Oversized order with an empty inner dimension and zero alpha: the whole
		// lower triangle comes out as beta times the old C.
		set_config(1'b0, 1'b1, 4'd15, 4'd0, 16'h0000, 16'h8000);
		push_compute(1'b0);
		drain();

		// Order zero with oversized depth emits nothing; zero beta drops old C.
		set_config(1'b1, 1'b1, 4'd0, 4'd15, 16'h8000, 16'h0000);
		push_compute(1'b0);
		push_word(OP_LOAD_C, 3'd1, 3'd0, 32'h0000_8000, 1'b0);
		drain();
		set_config(1'b0, 1'b0, 4'd2, 4'd1, 16'h7FFF, 16'h0000);
		push_compute(1'b0);
		drain();

		// Random phases: mostly loads followed by a compute, with some unused
		// codes mixed in; two phases run at the full size with extreme scales.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_idle(idle_mode_t'(p % 4));
			case (p)
				1: set_config(1'b0, 1'b1, 4'd8, 4'd8, 16'h7FFF, 16'h8000);
				3: set_config(1'b1, 1'b0, 4'd15, 4'd15, 16'h8000, 16'h0000);
				default: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					rand_dim(), rand_dim(), rand_scale(), rand_scale());
			endcase
			for (int w = 0; w < WORDS_PER_PHASE; w++) begin
				pick = $urandom_range(0, 99);
				if (pick < 62) begin
					push_word(OP_LOAD_A, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
						rand_elem(), 1'b0);
				end else if (pick < 86) begin
					push_word(OP_LOAD_C, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
						rand_elem(), 1'b0);
				end else if (pick < 94) begin
					push_compute($urandom_range(0, 3) == 0);
				end else begin
					push_word(OP_UNUSED, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
						$urandom, 1'b0);
				end
			end
			push_compute(1'b0);
			drain();
		end

		if (mismatches == 0 && expected_elems.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/srk_pkg.sv
sv/srk_mul.sv
sv/symmetric_rank_k_update_top.sv
tb/tb_symmetric_rank_k_update_top.sv
